// File: src/smx_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smx_pkg
// shared types and constants of the two-stack machine execute core
// ----------------------------------------------------------------------------
package smx_pkg;

  localparam int DATA_DEPTH_DEF   = 16;
  localparam int RETURN_DEPTH_DEF = 16;
  localparam int DATA_WIDTH_DEF   = 32;
  localparam int ADDR_BITS_DEF    = 8;

  localparam int OPCODE_W   = 3;
  localparam int OPERAND_W  = 32;
  localparam int CFG_W      = 8;
  localparam int IN_TDATA_W = ((OPCODE_W + OPERAND_W + 7) / 8) * 8;

  localparam logic [CFG_W-1:0] START_ADDR_RST = '0;

  typedef enum logic [OPCODE_W-1:0] {
    OP_PUSH  = 3'd0,
    OP_ADD   = 3'd1,
    OP_PRINT = 3'd2,
    OP_EXIT  = 3'd3,
    OP_CALL  = 3'd4,
    OP_RET   = 3'd5
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_OVER  = 2'd1,
    ST_UNDER = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    EX_HOLD,
    EX_ADV,
    EX_PUSH,
    EX_ADD,
    EX_PRINT,
    EX_CALL,
    EX_RET
  } ex_kind_t;

  typedef struct packed {
    ex_kind_t kind;
    status_t  status;
    logic     halted;
  } ex_ctrl_t;

endpackage

// File: src/stack_machine_execute_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_machine_execute_core
// execute unit of a two-stack machine with data and return stacks in memory
// ----------------------------------------------------------------------------
// Takes one instruction word per cycle while the output side is ready, and
// returns one result word for each, registered in the execute stage and then
// in the output register and held there while the output side is not ready.
// A decode stage keeps the stack depths and the halt flag, checks for overflow
// and underflow and reads the stack memories. An execute stage, once the
// registered memory read has returned, holds the instruction pointer, does
// the add and writes back, with the previous write forwarded. The stacks are
// not cleared at reset; only entries below the current depth are ever used.
// The start address register is taken once after reset; a failed push, add,
// print, call or return leaves all state and the pointer unchanged.
// ----------------------------------------------------------------------------
module stack_machine_execute_core
  import smx_pkg::*;
#(
  parameter int DATA_DEPTH   = DATA_DEPTH_DEF,
  parameter int RETURN_DEPTH = RETURN_DEPTH_DEF,
  parameter int DATA_WIDTH   = DATA_WIDTH_DEF,
  parameter int ADDR_BITS    = ADDR_BITS_DEF,
  localparam int OUT_W       = ADDR_BITS + DATA_WIDTH + 4,
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // opcode, operand
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // next_address, print_valid, print_value, halted, status
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [CFG_W-1:0]       cfg_data,
  input  logic                   cfg_valid,
  output logic                   cfg_ready
);

  localparam int DAW = $clog2(DATA_DEPTH);
  localparam int RAW = $clog2(RETURN_DEPTH);

  logic [CFG_W-1:0]      start_addr_r;
  opcode_t               opcode;
  logic [OPERAND_W-1:0]  operand;
  logic                  accept;
  ex_ctrl_t              ctrl;
  logic [DAW-1:0]        d_raddr_a, d_raddr_b, d_waddr_iss, d_waddr;
  logic [RAW-1:0]        r_raddr, r_waddr_iss, r_waddr;
  logic [DATA_WIDTH-1:0] d_top, d_second, d_wdata;
  logic [ADDR_BITS-1:0]  r_top, r_wdata;
  logic                  d_we, r_we;

  logic [ADDR_BITS-1:0]  next_address;
  logic                  print_valid;
  logic [DATA_WIDTH-1:0] print_value;
  logic                  halted;
  status_t               status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_addr_r <= START_ADDR_RST;
    end else if (cfg_valid && cfg_ready) begin
      start_addr_r <= cfg_data;
    end
  end

  assign opcode  = opcode_t'(in_tdata[OPCODE_W-1:0]);
  assign operand = in_tdata[OPCODE_W +: OPERAND_W];

  smx_issue #(
    .DATA_DEPTH   (DATA_DEPTH),
    .RETURN_DEPTH (RETURN_DEPTH)
  ) u_issue (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .opcode    (opcode),
    .ctrl      (ctrl),
    .d_raddr_a (d_raddr_a),
    .d_raddr_b (d_raddr_b),
    .d_waddr   (d_waddr_iss),
    .r_raddr   (r_raddr),
    .r_waddr   (r_waddr_iss)
  );

  smx_dstack #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DATA_DEPTH)
  ) u_dstack (
    .clk     (clk),
    .rst_n   (rst_n),
    .re      (accept),
    .raddr_a (d_raddr_a),
    .raddr_b (d_raddr_b),
    .we      (d_we),
    .waddr   (d_waddr),
    .wdata   (d_wdata),
    .rdata_a (d_top),
    .rdata_b (d_second)
  );

  smx_rstack #(
    .WIDTH (ADDR_BITS),
    .DEPTH (RETURN_DEPTH)
  ) u_rstack (
    .clk   (clk),
    .rst_n (rst_n),
    .re    (accept),
    .raddr (r_raddr),
    .we    (r_we),
    .waddr (r_waddr),
    .wdata (r_wdata),
    .rdata (r_top)
  );

  smx_exec #(
    .DATA_WIDTH   (DATA_WIDTH),
    .ADDR_BITS    (ADDR_BITS),
    .DATA_DEPTH   (DATA_DEPTH),
    .RETURN_DEPTH (RETURN_DEPTH)
  ) u_exec (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_tvalid),
    .in_ready         (in_tready),
    .accept           (accept),
    .ctrl_in          (ctrl),
    .operand_in       (operand),
    .d_waddr_in       (d_waddr_iss),
    .r_waddr_in       (r_waddr_iss),
    .start_addr       (start_addr_r),
    .d_top            (d_top),
    .d_second         (d_second),
    .r_top            (r_top),
    .d_we             (d_we),
    .d_waddr          (d_waddr),
    .d_wdata          (d_wdata),
    .r_we             (r_we),
    .r_waddr          (r_waddr),
    .r_wdata          (r_wdata),
    .out_valid        (out_tvalid),
    .out_ready        (out_tready),
    .out_next_address (next_address),
    .out_print_valid  (print_valid),
    .out_print_value  (print_value),
    .out_halted       (halted),
    .out_status       (status)
  );

  assign out_tdata = OUT_TDATA_W'({status, halted, print_value, print_valid, next_address});

endmodule

// File: src/smx_issue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smx_issue
// decode stage: tracks stack depths and halt, checks bounds, sets stack
// read and write addresses
// ----------------------------------------------------------------------------
module smx_issue
  import smx_pkg::*;
#(
  parameter int DATA_DEPTH   = DATA_DEPTH_DEF,
  parameter int RETURN_DEPTH = RETURN_DEPTH_DEF,
  localparam int DCW = $clog2(DATA_DEPTH + 1),
  localparam int DAW = $clog2(DATA_DEPTH),
  localparam int RCW = $clog2(RETURN_DEPTH + 1),
  localparam int RAW = $clog2(RETURN_DEPTH)
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           accept,
  input  opcode_t        opcode,
  output ex_ctrl_t       ctrl,
  output logic [DAW-1:0] d_raddr_a,
  output logic [DAW-1:0] d_raddr_b,
  output logic [DAW-1:0] d_waddr,
  output logic [RAW-1:0] r_raddr,
  output logic [RAW-1:0] r_waddr
);

  logic [DCW-1:0] dd_r, dd_nxt;
  logic [RCW-1:0] rd_r, rd_nxt;
  logic           halt_r, halt_nxt;
  logic [DCW-1:0] dd_m1, dd_m2;
  logic [RCW-1:0] rd_m1;

  assign dd_m1 = dd_r - DCW'(1);
  assign dd_m2 = dd_r - DCW'(2);
  assign rd_m1 = rd_r - RCW'(1);

  assign d_raddr_a = dd_m1[DAW-1:0];
  assign d_raddr_b = dd_m2[DAW-1:0];
  assign r_raddr   = rd_m1[RAW-1:0];
  assign r_waddr   = rd_r[RAW-1:0];

  always_comb begin
    dd_nxt      = dd_r;
    rd_nxt      = rd_r;
    halt_nxt    = halt_r;
    ctrl.kind   = EX_HOLD;
    ctrl.status = ST_OK;
    d_waddr     = dd_m2[DAW-1:0];
    if (!halt_r) begin
      unique case (opcode)
        OP_PUSH: begin
          d_waddr = dd_r[DAW-1:0];
          if (dd_r == DCW'(DATA_DEPTH)) begin
            ctrl.status = ST_OVER;
          end else begin
            ctrl.kind = EX_PUSH;
            dd_nxt    = dd_r + DCW'(1);
          end
        end
        OP_ADD: begin
          if (dd_r < DCW'(2)) begin
            ctrl.status = ST_UNDER;
          end else begin
            ctrl.kind = EX_ADD;
            dd_nxt    = dd_m1;
          end
        end
        OP_PRINT: begin
          if (dd_r == '0) begin
            ctrl.status = ST_UNDER;
          end else begin
            ctrl.kind = EX_PRINT;
            dd_nxt    = dd_m1;
          end
        end
        OP_EXIT: begin
          ctrl.kind = EX_ADV;
          halt_nxt  = 1'b1;
        end
        OP_CALL: begin
          if (rd_r == RCW'(RETURN_DEPTH)) begin
            ctrl.status = ST_OVER;
          end else begin
            ctrl.kind = EX_CALL;
            rd_nxt    = rd_r + RCW'(1);
          end
        end
        OP_RET: begin
          if (rd_r == '0) begin
            ctrl.status = ST_UNDER;
          end else begin
            ctrl.kind = EX_RET;
            rd_nxt    = rd_m1;
          end
        end
        default: begin
          ctrl.kind = EX_ADV;
        end
      endcase
    end
    ctrl.halted = halt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dd_r   <= '0;
      rd_r   <= '0;
      halt_r <= 1'b0;
    end else if (accept) begin
      dd_r   <= dd_nxt;
      rd_r   <= rd_nxt;
      halt_r <= halt_nxt;
    end
  end

endmodule

// File: src/smx_dstack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smx_dstack
// data stack memory: one write port, two registered read ports, with
// forwarding of the write that lands on the read edge
// ----------------------------------------------------------------------------
module smx_dstack
  import smx_pkg::*;
#(
  parameter int WIDTH = DATA_WIDTH_DEF,
  parameter int DEPTH = DATA_DEPTH_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             re,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] q_a_r, q_b_r;
  logic [AW-1:0]    ra_a_r, ra_b_r;
  logic             fwd_v_r;
  logic [AW-1:0]    fwd_addr_r;
  logic [WIDTH-1:0] fwd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      q_a_r  <= mem[raddr_a];
      q_b_r  <= mem[raddr_b];
      ra_a_r <= raddr_a;
      ra_b_r <= raddr_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_v_r <= 1'b0;
    end else if (we) begin
      fwd_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      fwd_addr_r <= waddr;
      fwd_data_r <= wdata;
    end
  end

  assign rdata_a = (fwd_v_r && fwd_addr_r == ra_a_r) ? fwd_data_r : q_a_r;
  assign rdata_b = (fwd_v_r && fwd_addr_r == ra_b_r) ? fwd_data_r : q_b_r;

endmodule

// File: src/smx_rstack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smx_rstack
// return stack memory: one write port, one registered read port, with
// forwarding of the write that lands on the read edge
// ----------------------------------------------------------------------------
module smx_rstack
  import smx_pkg::*;
#(
  parameter int WIDTH = ADDR_BITS_DEF,
  parameter int DEPTH = RETURN_DEPTH_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] q_r;
  logic [AW-1:0]    ra_r;
  logic             fwd_v_r;
  logic [AW-1:0]    fwd_addr_r;
  logic [WIDTH-1:0] fwd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      q_r  <= mem[raddr];
      ra_r <= raddr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_v_r <= 1'b0;
    end else if (we) begin
      fwd_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      fwd_addr_r <= waddr;
      fwd_data_r <= wdata;
    end
  end

  assign rdata = (fwd_v_r && fwd_addr_r == ra_r) ? fwd_data_r : q_r;

endmodule

// File: src/smx_exec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smx_exec
// execute stage: instruction pointer, adder, stack write-back and the
// output register
// ----------------------------------------------------------------------------
module smx_exec
  import smx_pkg::*;
#(
  parameter int DATA_WIDTH   = DATA_WIDTH_DEF,
  parameter int ADDR_BITS    = ADDR_BITS_DEF,
  parameter int DATA_DEPTH   = DATA_DEPTH_DEF,
  parameter int RETURN_DEPTH = RETURN_DEPTH_DEF,
  localparam int DAW = $clog2(DATA_DEPTH),
  localparam int RAW = $clog2(RETURN_DEPTH)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  accept,
  input  ex_ctrl_t              ctrl_in,
  input  logic [OPERAND_W-1:0]  operand_in,
  input  logic [DAW-1:0]        d_waddr_in,
  input  logic [RAW-1:0]        r_waddr_in,
  input  logic [CFG_W-1:0]      start_addr,
  input  logic [DATA_WIDTH-1:0] d_top,
  input  logic [DATA_WIDTH-1:0] d_second,
  input  logic [ADDR_BITS-1:0]  r_top,
  output logic                  d_we,
  output logic [DAW-1:0]        d_waddr,
  output logic [DATA_WIDTH-1:0] d_wdata,
  output logic                  r_we,
  output logic [RAW-1:0]        r_waddr,
  output logic [ADDR_BITS-1:0]  r_wdata,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [ADDR_BITS-1:0]  out_next_address,
  output logic                  out_print_valid,
  output logic [DATA_WIDTH-1:0] out_print_value,
  output logic                  out_halted,
  output status_t               out_status
);

  logic                  s1_v_r;
  ex_ctrl_t              s1_ctrl_r;
  logic [OPERAND_W-1:0]  s1_operand_r;
  logic [DAW-1:0]        s1_dwa_r;
  logic [RAW-1:0]        s1_rwa_r;
  logic                  s1_fire;

  logic [ADDR_BITS-1:0]  ip_r, ip_nxt, ip_adv;
  logic                  boot_r;

  logic                  out_v_r;
  logic [ADDR_BITS-1:0]  out_addr_r;
  logic                  out_pv_r;
  logic [DATA_WIDTH-1:0] out_pval_r;
  logic                  out_halt_r;
  status_t               out_st_r;

  logic [DATA_WIDTH-1:0] sum;
  logic                  pv;

  assign s1_fire  = s1_v_r && (!out_v_r || out_ready);
  assign in_ready = !s1_v_r || s1_fire;
  assign accept   = in_valid && in_ready;

  assign ip_adv = ip_r + ADDR_BITS'(1);
  assign sum    = d_second + d_top;
  assign pv     = (s1_ctrl_r.kind == EX_PRINT);

  always_comb begin
    unique case (s1_ctrl_r.kind)
      EX_HOLD:  ip_nxt = ip_r;
      EX_CALL:  ip_nxt = ADDR_BITS'(s1_operand_r);
      EX_RET:   ip_nxt = r_top;
      default:  ip_nxt = ip_adv;
    endcase
  end

  assign d_we    = s1_fire && (s1_ctrl_r.kind == EX_PUSH || s1_ctrl_r.kind == EX_ADD);
  assign d_waddr = s1_dwa_r;
  assign d_wdata = (s1_ctrl_r.kind == EX_PUSH) ? DATA_WIDTH'(s1_operand_r) : sum;
  assign r_we    = s1_fire && (s1_ctrl_r.kind == EX_CALL);
  assign r_waddr = s1_rwa_r;
  assign r_wdata = ip_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      boot_r  <= 1'b1;
      ip_r    <= '0;
    end else begin
      boot_r <= 1'b0;
      if (accept) begin
        s1_v_r <= 1'b1;
      end else if (s1_fire) begin
        s1_v_r <= 1'b0;
      end
      if (s1_fire) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
      if (boot_r) begin
        ip_r <= ADDR_BITS'(start_addr);
      end else if (s1_fire) begin
        ip_r <= ip_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ctrl_r    <= ctrl_in;
      s1_operand_r <= operand_in;
      s1_dwa_r     <= d_waddr_in;
      s1_rwa_r     <= r_waddr_in;
    end
    if (s1_fire) begin
      out_addr_r <= ip_nxt;
      out_pv_r   <= pv;
      out_pval_r <= pv ? d_top : '0;
      out_halt_r <= s1_ctrl_r.halted;
      out_st_r   <= s1_ctrl_r.status;
    end
  end

  assign out_valid        = out_v_r;
  assign out_next_address = out_addr_r;
  assign out_print_valid  = out_pv_r;
  assign out_print_value  = out_pval_r;
  assign out_halted       = out_halt_r;
  assign out_status       = out_st_r;

endmodule
